FILE: sv/indexed_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Concurrent assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ILE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ile_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list engine package
// Sizes, request and status codes, and the control word broadcast to cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width covers both the 8-bit position and the occupancy
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  // sign extension width, wider than any stored value
  localparam int EXT_W = 65;

  typedef enum logic [2:0] {
    KIND_READ     = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_INS_TAIL = 3'd2,
    KIND_INS_POS  = 3'd3,
    KIND_DELETE   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      pos;
    logic [IDX_W-1:0]      rd_pos;
    logic [VALUE_BITS-1:0] din;
  } cell_ctl_t;

endpackage

FILE: sv/ile_cell.sv
// ----------------------------------------------------------------------------
// Indexed list engine cell
// One list slot: takes the new value, its left or right neighbor, or holds.
// ----------------------------------------------------------------------------
module ile_cell (
  input  logic                           clk,
  input  ile_pkg::cell_ctl_t             ctl,
  input  logic [ile_pkg::IDX_W-1:0]      idx,
  input  logic [ile_pkg::VALUE_BITS-1:0] left_val,
  input  logic [ile_pkg::VALUE_BITS-1:0] right_val,
  output logic [ile_pkg::VALUE_BITS-1:0] val,
  output logic [ile_pkg::VALUE_BITS-1:0] rd_val
);

  logic [ile_pkg::VALUE_BITS-1:0] val_r;
  logic [ile_pkg::VALUE_BITS-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      ile_pkg::CELL_INS: begin
        if (idx == ctl.pos) begin
          val_nxt = ctl.din;
        end else if (idx > ctl.pos) begin
          val_nxt = left_val;
        end
      end
      ile_pkg::CELL_DEL: begin
        if (idx >= ctl.pos) begin
          val_nxt = right_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  // drive the read bus only from the addressed slot
  assign rd_val = (idx == ctl.rd_pos) ? val_r : '0;

endmodule

FILE: sv/indexed_list_engine.sv
// An accepted input transfer raises out_tvalid in the cycle after it.
// Throughput: one request per cycle unless a pending result is stalled by
// out_tready low; the slots of the cell row at and beyond the position shift in parallel in the accepting cycle.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// slot contents are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed values with read, insert and delete by position.
// ----------------------------------------------------------------------------
module indexed_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] read_value, [33:32] status, [40:34] count
);

  localparam int VB = ile_pkg::VALUE_BITS;
  localparam int CW = ile_pkg::CNT_W;
  localparam int MW = ile_pkg::CMP_W;
  localparam int EW = ile_pkg::EXT_W;
  localparam int IW = ile_pkg::IDX_W;

  logic                out_valid_r;
  logic [47:0]         out_data_r;
  logic [CW-1:0]       occ_r;
  logic [CW-1:0]       occ_nxt;

  logic                accept;
  ile_pkg::kind_t      kind;
  ile_pkg::status_t    status;
  ile_pkg::cell_ctl_t  ctl;
  logic [31:0]         rd_value;
  logic [MW-1:0]       pos_ext;
  logic [MW-1:0]       occ_ext;
  logic [MW-1:0]       occ_nxt_ext;
  logic [MW-1:0]       ins_pos;
  logic [EW-1:0]       din_wide;
  logic [EW-1:0]       rd_wide;
  logic [VB-1:0]       rd_or;

  logic [VB-1:0] cell_val [ile_pkg::CAPACITY];
  logic [VB-1:0] cell_rd  [ile_pkg::CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign kind      = ile_pkg::kind_t'(in_tuser);

  assign pos_ext     = MW'(in_tdata[7:0]);
  assign occ_ext     = MW'(occ_r);
  assign occ_nxt_ext = MW'(occ_nxt);
  assign din_wide    = {{(EW-32){in_tdata[39]}}, in_tdata[39:8]};
  assign rd_wide     = {{(EW-VB){rd_or[VB-1]}}, rd_or};

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    status     = ile_pkg::ST_DONE;
    rd_value   = '0;
    occ_nxt    = occ_r;
    ctl.op     = ile_pkg::CELL_HOLD;
    ctl.din    = din_wide[VB-1:0];
    ctl.rd_pos = pos_ext[IW-1:0];
    ins_pos    = pos_ext;
    if (kind == ile_pkg::KIND_INS_HEAD) begin
      ins_pos = '0;
    end else if (kind == ile_pkg::KIND_INS_TAIL) begin
      ins_pos = occ_ext;
    end
    ctl.pos    = ins_pos[IW-1:0];
    unique case (kind) inside
      ile_pkg::KIND_READ: begin
        if (pos_ext < occ_ext) begin
          rd_value = rd_wide[31:0];
        end else begin
          rd_value = '1;
          status   = ile_pkg::ST_RANGE;
        end
      end
      ile_pkg::KIND_INS_HEAD, ile_pkg::KIND_INS_TAIL, ile_pkg::KIND_INS_POS: begin
        if (ins_pos > occ_ext) begin
          status = ile_pkg::ST_RANGE;
        end else if (occ_r == CW'(ile_pkg::CAPACITY)) begin
          status = ile_pkg::ST_FULL;
        end else begin
          ctl.op  = accept ? ile_pkg::CELL_INS : ile_pkg::CELL_HOLD;
          occ_nxt = CW'(occ_r + 1'b1);
        end
      end
      ile_pkg::KIND_DELETE: begin
        ctl.pos = pos_ext[IW-1:0];
        if (pos_ext < occ_ext) begin
          ctl.op  = accept ? ile_pkg::CELL_DEL : ile_pkg::CELL_HOLD;
          occ_nxt = CW'(occ_r - 1'b1);
        end else begin
          status = ile_pkg::ST_RANGE;
        end
      end
      default: begin
        status = ile_pkg::ST_RANGE;
      end
    endcase
  end

  for (genvar g = 0; g < ile_pkg::CAPACITY; g++) begin : g_cell
    logic [VB-1:0] left_val;
    logic [VB-1:0] right_val;
    if (g == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_body
      assign left_val = cell_val[g-1];
    end
    if (g == ile_pkg::CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_next
      assign right_val = cell_val[g+1];
    end
    ile_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IW'(g)),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g]),
      .rd_val    (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      occ_r       <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        occ_r       <= occ_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {7'd0, occ_nxt_ext[6:0], status, rd_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/indexed_list_engine_checker.sv
// ----------------------------------------------------------------------------
// Indexed list engine checker
// Port-level assertions on result transfers, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_macros.svh"

module indexed_list_engine_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic [1:0] status;
  logic [6:0] count;

  assign status = out_tdata[33:32];
  assign count  = out_tdata[40:34];

  // a stalled result holds its payload
  `ILE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  // a new result needs an input transfer in the cycle before
  `ILE_ASSERT_NOW(a_rose_accept, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready), "result without a request")
  // a full status is only reported with the list at capacity
  `ILE_ASSERT_NOW(a_full_count, clk, rst_n, out_tvalid && (status == ile_pkg::ST_FULL), count == 7'(ile_pkg::CAPACITY), "full status below capacity")
  // count stays in range and status is a known code
  `ILE_ASSERT_NOW(a_count_range, clk, rst_n, out_tvalid, (count <= 7'(ile_pkg::CAPACITY)) && (status != 2'd3), "count or status out of range")

endmodule

bind indexed_list_engine indexed_list_engine_checker u_checker (.*);
